// ===== rtl/fcds_pkg.sv =====
// ----------------------------------------------------------------------------
// fcds_pkg
// Shared types and constants for the fractional clock divider search.
// ----------------------------------------------------------------------------
package fcds_pkg;

    localparam int unsigned SRC_CLK_W      = 28;
    localparam int unsigned TARGET_W       = 26;
    localparam int unsigned BITS_W         = 10;
    localparam int unsigned BDIV_W         = 8;
    localparam int unsigned MULT_W         = 8;
    localparam int unsigned DIVR_W         = 12;
    localparam int unsigned DENOM_W        = 20;
    localparam int unsigned NUM_W          = 44;
    localparam int unsigned DVD_W          = 46;
    localparam int unsigned DVS_W          = 27;
    localparam int unsigned BEST_W         = 32;

    localparam logic [SRC_CLK_W-1:0] SRC_CLK_RESET = 28'd96000000;
    localparam logic [BEST_W-1:0]    ERR_START     = 32'd2560000000;
    localparam logic [TARGET_W-1:0]  ERR_MAX       = 26'h3FFFFFF;

    localparam int unsigned MAX_MULT_DEF  = 255;
    localparam int unsigned DIV_LIMIT_DEF = 4096;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_DEN     = 11'b000_0000_0010,
        S_BASE_GO = 11'b000_0000_0100,
        S_BASE_WT = 11'b000_0000_1000,
        S_NUM     = 11'b000_0001_0000,
        S_D_GO    = 11'b000_0010_0000,
        S_D_WT    = 11'b000_0100_0000,
        S_F_GO    = 11'b000_1000_0000,
        S_F_WT    = 11'b001_0000_0000,
        S_EVAL    = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } t_state;

endpackage

// ===== rtl/fractional_clock_divider_search.sv =====
// ----------------------------------------------------------------------------
// fractional_clock_divider_search
// Searches multiplier/divisor pairs that bring the source clock closest to a
// wanted sample rate, using one shared serial divider under a sequencer.
//
//  channel   handshake          payload
//  config    i_cfg_wr_en        i_cfg_wr_data (source clock, Hz)
//  request   start / busy       i_target_rate, i_bits_per_frame,
//                               i_bit_clock_divider
//  result    o_done (strobe)    o_multiplier_minus_one, o_divisor_minus_one,
//                               o_best_error, o_found
//
//  Each division loads its operands, runs 46 steps and then raises done. A
//  request runs one base division, then up to MAX_MULTIPLIER candidates of
//  two divisions each (one when the divisor is out of range), stopping early
//  on an exact match.
//  busy is high from acceptance until the result strobe. Reset is synchronous,
//  active low. The receiver cannot stall; o_done lasts one cycle.
// ----------------------------------------------------------------------------
module fractional_clock_divider_search #(
    parameter int unsigned MAX_MULTIPLIER = fcds_pkg::MAX_MULT_DEF,
    parameter int unsigned DIVISOR_LIMIT  = fcds_pkg::DIV_LIMIT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [fcds_pkg::SRC_CLK_W-1:0]   i_cfg_wr_data,
    input  logic                             start,
    input  logic [fcds_pkg::TARGET_W-1:0]    i_target_rate,
    input  logic [fcds_pkg::BITS_W-1:0]      i_bits_per_frame,
    input  logic [fcds_pkg::BDIV_W-1:0]      i_bit_clock_divider,
    output logic                             busy,
    output logic                             o_done,
    output logic [fcds_pkg::MULT_W-1:0]      o_multiplier_minus_one,
    output logic [fcds_pkg::DIVR_W-1:0]      o_divisor_minus_one,
    output logic [fcds_pkg::TARGET_W-1:0]    o_best_error,
    output logic                             o_found
);
    import fcds_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [SRC_CLK_W-1:0] r_src_clk;
    logic [TARGET_W-1:0] r_target;
    logic [BITS_W-1:0]   r_bits;
    logic [BDIV_W-1:0]   r_bdiv;
    logic [DENOM_W-1:0]  r_denom;
    logic [SRC_CLK_W-1:0] r_base;
    logic [MULT_W-1:0]   r_m;
    logic [NUM_W-1:0]    r_num;
    logic [DIVR_W-1:0]   r_d;
    logic [DVD_W-1:0]    r_err;
    logic [BEST_W-1:0]   r_best;
    logic [MULT_W-1:0]   r_best_m;
    logic [DIVR_W-1:0]   r_best_d;
    logic                r_found;

    logic                div_start;
    logic [DVD_W-1:0]    div_dvd;
    logic [DVS_W-1:0]    div_dvs;
    t_div_stat           div_stat;
    logic [DVD_W-1:0]    div_q;
    logic                d_bad;
    logic                last_m;
    logic [DVD_W-1:0]    tgt_ext;

    assign tgt_ext = DVD_W'(r_target);
    assign d_bad   = (div_q == '0) || (div_q >= DVD_W'(DIVISOR_LIMIT));
    assign last_m  = r_m == MULT_W'(MAX_MULTIPLIER);

    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        unique case (r_state)
            S_BASE_GO: begin
                div_start = (r_target != '0) && (r_denom != '0);
                div_dvd   = DVD_W'(r_src_clk);
                div_dvs   = DVS_W'(r_denom);
            end
            S_D_GO: begin
                div_start = 1'b1;
                div_dvd   = {r_num, 1'b0} + tgt_ext;
                div_dvs   = {r_target, 1'b0};
            end
            S_F_GO: begin
                div_start = 1'b1;
                div_dvd   = {r_num, 1'b0} + DVD_W'(r_d);
                div_dvs   = DVS_W'({r_d, 1'b0});
            end
            default: begin
            end
        endcase
    end

    fcds_div #(
        .NW (DVD_W),
        .DW (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_stat     (div_stat),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (start) n_state = S_DEN;
            S_DEN:     n_state = S_BASE_GO;
            S_BASE_GO: n_state = div_start ? S_BASE_WT : S_DONE;
            S_BASE_WT: if (div_stat.done) n_state = S_NUM;
            S_NUM:     n_state = S_D_GO;
            S_D_GO:    n_state = S_D_WT;
            S_D_WT: begin
                if (div_stat.done) begin
                    if (!d_bad) begin
                        n_state = S_F_GO;
                    end else if (last_m) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_NUM;
                    end
                end
            end
            S_F_GO:    n_state = S_F_WT;
            S_F_WT:    if (div_stat.done) n_state = S_EVAL;
            S_EVAL: begin
                if ((r_err < DVD_W'(r_best)) && (r_err == '0)) begin
                    n_state = S_DONE;
                end else if (last_m) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_NUM;
                end
            end
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_src_clk <= SRC_CLK_RESET;
            r_found   <= 1'b0;
            o_done    <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= r_state == S_DONE;
            if (i_cfg_wr_en) begin
                r_src_clk <= i_cfg_wr_data;
            end
            if (r_state == S_IDLE && start) begin
                r_found <= 1'b0;
            end else if (r_state == S_EVAL && r_err < DVD_W'(r_best)) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_target <= i_target_rate;
                    r_bits   <= i_bits_per_frame;
                    r_bdiv   <= i_bit_clock_divider;
                    r_best   <= ERR_START;
                    r_m      <= MULT_W'(1);
                end
            end
            S_DEN: begin
                r_denom <= {(DENOM_W-1)'(r_bits) * (DENOM_W-1)'({1'b0, r_bdiv} + 9'd1),
                            1'b0};
            end
            S_BASE_WT: begin
                if (div_stat.done) r_base <= div_q[SRC_CLK_W-1:0];
            end
            S_NUM: begin
                r_num <= {(NUM_W-8)'(r_base) * (NUM_W-8)'(r_m), 8'd0};
            end
            S_D_WT: begin
                if (div_stat.done) begin
                    r_d <= div_q[DIVR_W-1:0];
                    if (d_bad) r_m <= r_m + 1'b1;
                end
            end
            S_F_WT: begin
                if (div_stat.done) begin
                    r_err <= (div_q > tgt_ext) ? div_q - tgt_ext : tgt_ext - div_q;
                end
            end
            S_EVAL: begin
                if (r_err < DVD_W'(r_best)) begin
                    r_best   <= r_err[BEST_W-1:0];
                    r_best_m <= r_m;
                    r_best_d <= r_d;
                end
                r_m <= r_m + 1'b1;
            end
            S_DONE: begin
                o_found <= r_found;
                if (r_found) begin
                    o_multiplier_minus_one <= r_best_m - 1'b1;
                    o_divisor_minus_one    <= r_best_d - 1'b1;
                    o_best_error <= (r_best > BEST_W'(ERR_MAX)) ? ERR_MAX
                                                                : r_best[TARGET_W-1:0];
                end else begin
                    o_multiplier_minus_one <= '0;
                    o_divisor_minus_one    <= '0;
                    o_best_error           <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign busy = r_state != S_IDLE;

`ifndef ASSERT_OFF
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted without going busy");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == S_BASE_WT || r_state == S_D_WT ||
                           r_state == S_F_WT))
        else $error("divider running outside a wait state");

    a_found_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_found |-> 32'(o_divisor_minus_one) < 32'(DIVISOR_LIMIT - 1))
        else $error("divisor out of range on result");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_found |-> (o_best_error == '0 && o_divisor_minus_one == '0))
        else $error("non-zero result without a match");
`endif

endmodule

// ===== rtl/fcds_div.sv =====
// ----------------------------------------------------------------------------
// fcds_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcds_div #(
    parameter int unsigned NW = fcds_pkg::DVD_W,
    parameter int unsigned DW = fcds_pkg::DVS_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NW-1:0]       i_dividend,
    input  logic [DW-1:0]       i_divisor,
    output fcds_pkg::t_div_stat o_stat,
    output logic [NW-1:0]       o_quotient
);
    import fcds_pkg::*;

    localparam int unsigned CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_dvs;

    logic [DW:0]   rem_sh;
    logic          ge;
    logic [DW:0]   rem_sub;

    assign rem_sh  = {r_rem, r_quo[NW-1]};
    assign ge      = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule
